/* design/fdc_pkg.sv */
// ----------------------------------------------------------------------------
// fdc_pkg
// Types, constants and the month table shared by the datestamp converter.
// ----------------------------------------------------------------------------
package fdc_pkg;

  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 72;

  localparam logic [15:0] EpochGap   = 16'd730;
  localparam logic [15:0] LastFatDay = 16'd47481;
  localparam logic [10:0] MaxMinutes = 11'd1439;
  localparam logic [11:0] MaxTicks   = 12'd2999;

  // Reciprocal constants for division by 365, 60 and 100.
  localparam logic [31:0] RecipYear   = 32'd45965;
  localparam logic [21:0] RecipHour   = 22'd1093;
  localparam logic [22:0] RecipSecPair = 23'd2622;

  typedef enum logic {
    OP_TO_STAMP = 1'b0,
    OP_TO_FAT   = 1'b1
  } op_t;

  typedef struct packed {
    op_t         operation;
    logic [15:0] fat_date_in;
    logic [15:0] fat_time_in;
    logic [15:0] days_in;
    logic [10:0] minutes_in;
    logic [11:0] ticks_in;
  } in_t;

  typedef struct packed {
    op_t         operation;
    logic        bad;
    // FAT to stamp
    logic [15:0] yr_days;
    logic [5:0]  leap_days;
    logic [8:0]  mon_start;
    logic        leap_adj;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [4:0]  sec2;
    // stamp to FAT
    logic [15:0] day_ofs;
    logic [7:0]  year_est;
    logic [10:0] mins_sat;
    logic [4:0]  hour_q;
    logic [4:0]  sec2_q;
  } s1_t;

  typedef struct packed {
    op_t         operation;
    logic        bad;
    logic [16:0] days_sum;
    logic [10:0] minutes_sum;
    logic [11:0] ticks_prod;
    logic [6:0]  year;
    logic [8:0]  day_of_year;
    logic [4:0]  hour_q;
    logic [5:0]  minute_q;
    logic [4:0]  sec2_q;
  } s2_t;

  typedef struct packed {
    logic        out_of_range;
    logic [15:0] fat_time_out;
    logic [15:0] fat_date_out;
    logic [11:0] ticks_out;
    logic [10:0] minutes_out;
    logic [15:0] days_out;
  } res_t;

  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] val;
    unique case (idx)
      4'd0:    val = 9'd0;
      4'd1:    val = 9'd31;
      4'd2:    val = 9'd59;
      4'd3:    val = 9'd90;
      4'd4:    val = 9'd120;
      4'd5:    val = 9'd151;
      4'd6:    val = 9'd181;
      4'd7:    val = 9'd212;
      4'd8:    val = 9'd243;
      4'd9:    val = 9'd273;
      4'd10:   val = 9'd304;
      4'd11:   val = 9'd334;
      default: val = 9'd0;
    endcase
    return val;
  endfunction

endpackage

/* design/fat_datestamp_converter_core.sv */
// ----------------------------------------------------------------------------
// fat_datestamp_converter_core
// Converts between FAT date/time words and a day/minute/tick stamp.
// ----------------------------------------------------------------------------
// The core takes one word per clock while the output is ready and returns one
// result word through its three register stages: unpack with the constant
// multiplications, the day and year remainder arithmetic, and the month
// search with result assembly. Each stage holds its word under back-pressure,
// so up to three words can be in flight while the output waits. The tuser
// bit on the input picks the direction and the tuser bit on the output flags
// an invalid month or day count, in which case the data word is all zeros.
module fat_datestamp_converter_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // fat_date_in, fat_time_in, days_in, minutes_in, ticks_in, zero pad
  input  logic [fdc_pkg::InDataW-1:0]    in_tdata,
  // operation
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // days_out, minutes_out, ticks_out, fat_date_out, fat_time_out, zero pad
  output logic [fdc_pkg::OutDataW-1:0]   out_tdata,
  // out_of_range
  output logic                           out_tuser
);
  import fdc_pkg::*;

  in_t  in_word;
  s1_t  s1_data;
  s2_t  s2_data;
  res_t res_data;
  logic s1_valid;
  logic s1_ready;
  logic s2_valid;
  logic s2_ready;

  always_comb begin
    in_word.operation   = op_t'(in_tuser);
    in_word.fat_date_in = in_tdata[15:0];
    in_word.fat_time_in = in_tdata[31:16];
    in_word.days_in     = in_tdata[47:32];
    in_word.minutes_in  = in_tdata[58:48];
    in_word.ticks_in    = in_tdata[70:59];
  end

  fdc_unpack u_unpack (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_tvalid),
    .ready_o (in_tready),
    .data_i  (in_word),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  fdc_arith u_arith (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  fdc_pack u_pack (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (out_tvalid),
    .ready_i (out_tready),
    .data_o  (res_data)
  );

  assign out_tdata = {1'b0, res_data.fat_time_out, res_data.fat_date_out,
                      res_data.ticks_out, res_data.minutes_out, res_data.days_out};
  assign out_tuser = res_data.out_of_range;

  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("Out-of-range word carries nonzero data.");

  a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[38:0] == '0) || (out_tdata[70:39] == '0))
    else $error("Both conversion directions carry data.");

  a_ticks_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[38:27] <= 12'd3100)
    else $error("Tick result exceeds its range.");

  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("Input stalled while the output drains.");

endmodule

/* design/fdc_unpack.sv */
// ----------------------------------------------------------------------------
// fdc_unpack
// First stage: field split, range checks and the constant multiplications.
// ----------------------------------------------------------------------------
module fdc_unpack (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         valid_i,
  output logic         ready_o,
  input  fdc_pkg::in_t data_i,
  output logic         valid_o,
  input  logic         ready_i,
  output fdc_pkg::s1_t data_o
);
  import fdc_pkg::*;

  logic        valid_r;
  s1_t         data_r;
  s1_t         data_nxt;
  logic [6:0]  yr;
  logic [3:0]  mon;
  logic [15:0] ofs;
  logic [31:0] yr_prod;
  logic [10:0] mins;
  logic [11:0] ticks;
  logic [21:0] hr_prod;
  logic [22:0] sec_prod;
  logic        bad_fat;
  logic        bad_stamp;

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign data_o  = data_r;

  always_comb begin
    yr        = data_i.fat_date_in[15:9];
    mon       = data_i.fat_date_in[8:5];
    bad_fat   = (mon == 4'd0) || (mon > 4'd12);
    bad_stamp = (data_i.days_in < EpochGap) || (data_i.days_in > LastFatDay);
    ofs       = data_i.days_in - EpochGap;
    yr_prod   = {16'd0, ofs} * RecipYear;
    mins      = (data_i.minutes_in > MaxMinutes) ? MaxMinutes : data_i.minutes_in;
    ticks     = (data_i.ticks_in > MaxTicks) ? MaxTicks : data_i.ticks_in;
    hr_prod   = {11'd0, mins} * RecipHour;
    sec_prod  = {11'd0, ticks} * RecipSecPair;

    data_nxt.operation = data_i.operation;
    data_nxt.bad       = (data_i.operation == OP_TO_FAT) ? bad_stamp : bad_fat;
    data_nxt.yr_days   = {9'd0, yr} * 16'd365;
    data_nxt.leap_days = 6'(({1'b0, yr} + 8'd3) >> 2);
    data_nxt.mon_start = month_start(mon - 4'd1);
    data_nxt.leap_adj  = (yr[1:0] == 2'd0) && (mon >= 4'd3);
    data_nxt.day       = data_i.fat_date_in[4:0];
    data_nxt.hour      = data_i.fat_time_in[15:11];
    data_nxt.minute    = data_i.fat_time_in[10:5];
    data_nxt.sec2      = data_i.fat_time_in[4:0];
    data_nxt.day_ofs   = ofs;
    data_nxt.year_est  = yr_prod[31:24];
    data_nxt.mins_sat  = mins;
    data_nxt.hour_q    = hr_prod[20:16];
    data_nxt.sec2_q    = sec_prod[22:18];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* design/fdc_arith.sv */
// ----------------------------------------------------------------------------
// fdc_arith
// Second stage: day sum, time products and the year remainder with correction.
// ----------------------------------------------------------------------------
module fdc_arith (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         valid_i,
  output logic         ready_o,
  input  fdc_pkg::s1_t data_i,
  output logic         valid_o,
  input  logic         ready_i,
  output fdc_pkg::s2_t data_o
);
  import fdc_pkg::*;

  logic               valid_r;
  s2_t                data_r;
  s2_t                data_nxt;
  logic [16:0]        q_days;
  logic [8:0]         q_leap;
  logic signed [17:0] rem_raw;
  logic [7:0]         year_dec;
  logic [17:0]        rem_fix;

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign data_o  = data_r;

  always_comb begin
    q_days   = {9'd0, data_i.year_est} * 17'd365;
    q_leap   = ({1'b0, data_i.year_est} + 9'd3) >> 2;
    rem_raw  = $signed({2'd0, data_i.day_ofs}) - $signed({1'b0, q_days})
             - $signed({9'd0, q_leap});
    year_dec = data_i.year_est - 8'd1;
    rem_fix  = 18'(rem_raw) + 18'd365 + {17'd0, (year_dec[1:0] == 2'd0)};

    data_nxt.operation   = data_i.operation;
    data_nxt.bad         = data_i.bad;
    data_nxt.days_sum    = {1'b0, EpochGap} + {1'b0, data_i.yr_days}
                         + {11'd0, data_i.leap_days} + {8'd0, data_i.mon_start}
                         + {12'd0, data_i.day} + {16'd0, data_i.leap_adj} - 17'd1;
    data_nxt.minutes_sum = 11'({6'd0, data_i.hour} * 11'd60) + {5'd0, data_i.minute};
    data_nxt.ticks_prod  = {7'd0, data_i.sec2} * 12'd100;
    if (rem_raw < 0) begin
      data_nxt.year        = year_dec[6:0];
      data_nxt.day_of_year = rem_fix[8:0];
    end else begin
      data_nxt.year        = data_i.year_est[6:0];
      data_nxt.day_of_year = rem_raw[8:0];
    end
    data_nxt.hour_q   = data_i.hour_q;
    data_nxt.minute_q = 6'(data_i.mins_sat - 11'({6'd0, data_i.hour_q} * 11'd60));
    data_nxt.sec2_q   = data_i.sec2_q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* design/fdc_pack.sv */
// ----------------------------------------------------------------------------
// fdc_pack
// Third stage: month search, final range check and result word assembly.
// ----------------------------------------------------------------------------
module fdc_pack (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  output logic          ready_o,
  input  fdc_pkg::s2_t  data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output fdc_pkg::res_t data_o
);
  import fdc_pkg::*;

  logic       valid_r;
  res_t       data_r;
  res_t       data_nxt;
  logic       leap;
  logic [8:0] rem_adj;
  logic [3:0] mon_cnt;
  logic [3:0] mon;
  logic [4:0] dd;
  logic       bad_sum;
  logic       bad;

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign data_o  = data_r;

  always_comb begin
    leap    = (data_i.year[1:0] == 2'd0);
    rem_adj = data_i.day_of_year
            - {8'd0, (leap && (data_i.day_of_year > 9'd59))};
    mon_cnt = 4'd1;
    for (int i = 1; i < 12; i++) begin
      if (rem_adj >= month_start(4'(i))) begin
        mon_cnt = mon_cnt + 4'd1;
      end
    end
    if (leap && (data_i.day_of_year == 9'd59)) begin
      mon = 4'd2;
      dd  = 5'd29;
    end else begin
      mon = mon_cnt;
      dd  = 5'(rem_adj - month_start(mon_cnt - 4'd1) + 9'd1);
    end

    bad_sum = (data_i.days_sum < {1'b0, EpochGap})
           || (data_i.days_sum > {1'b0, LastFatDay});
    bad     = data_i.bad || ((data_i.operation == OP_TO_STAMP) && bad_sum);

    data_nxt = '0;
    data_nxt.out_of_range = bad;
    if (!bad) begin
      if (data_i.operation == OP_TO_STAMP) begin
        data_nxt.days_out    = data_i.days_sum[15:0];
        data_nxt.minutes_out = data_i.minutes_sum;
        data_nxt.ticks_out   = data_i.ticks_prod;
      end else begin
        data_nxt.fat_date_out = {data_i.year, mon, dd};
        data_nxt.fat_time_out = {data_i.hour_q, data_i.minute_q, data_i.sec2_q};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      data_r <= data_nxt;
    end
  end

endmodule
